### rtl/tscc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tscc_pkg
// Shared types and constants for the strongly connected component finder.
// ----------------------------------------------------------------------------
package tscc_pkg;

  localparam int unsigned MaxNodes = 64;
  localparam int unsigned MaxEdges = 1024;
  localparam int unsigned NodeW    = 6;
  localparam int unsigned CntW     = 7;
  localparam int unsigned EdgeW    = 10;
  localparam int unsigned LinkW    = 11;

  typedef struct packed {
    logic [5:0] source_node;
    logic [5:0] target_node;
    logic       edge_valid;
    logic       last_item;
  } tscc_in_t;

  typedef struct packed {
    logic [6:0] total_components;
    logic [6:0] component_position;
    logic [5:0] node_id;
    logic       last_in_component;
    logic       last_of_all;
    logic       edges_dropped;
  } tscc_out_t;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_LOAD_WR,
    ST_ROOT,
    ST_ENTER,
    ST_FRAME_RD,
    ST_FRAME_WT,
    ST_EDGE_WT,
    ST_TGT_WT,
    ST_FIN,
    ST_POP_RD,
    ST_POP_WT,
    ST_PAR_RD,
    ST_PAR_WT,
    ST_OUT_RD,
    ST_OUT_WT,
    ST_OUT,
    ST_CLEAR
  } tscc_state_e;

endpackage : tscc_pkg
`default_nettype wire

### rtl/tarjan_scc_finder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tarjan_scc_finder
// Tarjan strongly connected components over a stored edge list.
// ----------------------------------------------------------------------------
// Edge words are taken one at a time while loading; each valid in-range edge
// is appended to its source's linked list in edge memory while it has room.
// A word with last_item starts the search: the block then stalls its input
// while a sequencer walks the call stack, node stack and per-node tables,
// held in single-port synchronous memories with registered reads (visited
// and on-stack flags are registers). The output then gives one word per
// member, each component led by the ST_OUT_RD and ST_OUT_WT reads. A final
// pass over all 64 nodes resets the adjacency heads and flags, and the same
// pass runs after reset. A stored edge is appended, then linked with the
// input stalled; any other word is taken without a stall.
// ----------------------------------------------------------------------------
module tarjan_scc_finder import tscc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cfg_we_i,
  input  wire logic [6:0] cfg_wdata_i,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire tscc_in_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output tscc_out_t      out_word_o
);

  // memories
  logic [NodeW-1:0] tgt_mem   [MaxEdges];
  logic [LinkW-1:0] nxt_mem   [MaxEdges];
  logic [LinkW-1:0] head_mem  [MaxNodes];
  logic [EdgeW-1:0] tail_mem  [MaxNodes];
  logic [CntW-1:0]  disc_mem  [MaxNodes];
  logic [CntW-1:0]  low_mem   [MaxNodes];
  logic [NodeW-1:0] nstk_mem  [MaxNodes];
  logic [NodeW-1:0] fnode_mem [MaxNodes];
  logic [LinkW-1:0] fedge_mem [MaxNodes];
  logic [NodeW-1:0] mem_list  [MaxNodes];
  logic [CntW-1:0]  cend_mem  [MaxNodes];
  logic [MaxNodes-1:0] vis_q, ons_q, vis_d, ons_d;

  tscc_state_e state_q, state_d;
  logic [6:0]  ncfg_q;
  logic [LinkW-1:0] ecnt_q, ecnt_d;
  logic        ovf_q, ovf_d;
  logic [CntW-1:0] sp_q, sp_d, dep_q, dep_d, vc_q, vc_d, mc_q, mc_d, cf_q, cf_d;
  logic [CntW-1:0] root_q, root_d, k_q, k_d, m_q, m_d, beg_q, beg_d, end_q, end_d;
  logic [NodeW-1:0] cur_q, cur_d, x_q, x_d, s_q, s_d;
  logic [LinkW-1:0] e_q, e_d;
  logic [CntW-1:0]  curlow_q, curlow_d;
  logic [6:0]  n_eff;
  tscc_out_t   ob_q, ob_d;
  logic        ov_q, ov_d;

  // memory read data
  logic [LinkW-1:0] head_rd;
  logic [NodeW-1:0] tgt_rd;
  logic [LinkW-1:0] nxt_rd;
  logic [CntW-1:0]  disc_rd, low_rd, cend_rd;
  logic [NodeW-1:0] fnode_rd, nstk_rd, mem_rd;
  logic [LinkW-1:0] fedge_rd;

  // memory control
  logic [NodeW-1:0] head_a, tail_a, disc_a, low_a, nstk_a, fr_a, ml_a, ce_a;
  logic [EdgeW-1:0] edge_a;
  logic head_we, tail_we, tgt_we, nxt_we, disc_we, low_we, nstk_we, fr_we, fe_we;
  logic ml_we, ce_we;
  logic [LinkW-1:0] head_wd, nxt_wd, fe_wd;
  logic [EdgeW-1:0] tail_wd;
  logic [NodeW-1:0] tgt_wd, nstk_wd, fn_wd, ml_wd;
  logic [CntW-1:0]  disc_wd, low_wd, ce_wd;
  logic [EdgeW-1:0] nxt_a;

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_a] <= head_wd;
    head_rd <= head_mem[head_a];
    if (tail_we) tail_mem[tail_a] <= tail_wd;
    if (tgt_we) tgt_mem[edge_a] <= tgt_wd;
    tgt_rd <= tgt_mem[edge_a];
    if (nxt_we) nxt_mem[nxt_a] <= nxt_wd;
    nxt_rd <= nxt_mem[nxt_a];
    if (disc_we) disc_mem[disc_a] <= disc_wd;
    disc_rd <= disc_mem[disc_a];
    if (low_we) low_mem[low_a] <= low_wd;
    low_rd <= low_mem[low_a];
    if (nstk_we) nstk_mem[nstk_a] <= nstk_wd;
    nstk_rd <= nstk_mem[nstk_a];
    if (fr_we) fnode_mem[fr_a] <= fn_wd;
    if (fr_we || fe_we) fedge_mem[fr_a] <= fe_wd;
    fnode_rd <= fnode_mem[fr_a];
    fedge_rd <= fedge_mem[fr_a];
    if (ml_we) mem_list[ml_a] <= ml_wd;
    mem_rd <= mem_list[ml_a];
    if (ce_we) cend_mem[ce_a] <= ce_wd;
    cend_rd <= cend_mem[ce_a];
  end

  logic [EdgeW-1:0] tail_rd;
  always_ff @(posedge clk_i) begin
    tail_rd <= tail_mem[tail_a];
  end

  assign n_eff = (ncfg_q > 7'(MaxNodes)) ? 7'(MaxNodes) : ncfg_q;

  logic in_acc, edge_ok, is_last_node;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign edge_ok = in_word_i.edge_valid && ({1'b0, in_word_i.source_node} < n_eff)
                   && ({1'b0, in_word_i.target_node} < n_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      ncfg_q  <= 7'(MaxNodes);
      ecnt_q  <= '0;
      ovf_q   <= 1'b0;
      sp_q <= '0; dep_q <= '0; vc_q <= 7'd1; mc_q <= '0; cf_q <= '0;
      root_q <= '0; k_q <= '0;
      vis_q <= '0; ons_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) ncfg_q <= cfg_wdata_i;
      ecnt_q <= ecnt_d; ovf_q <= ovf_d;
      sp_q <= sp_d; dep_q <= dep_d; vc_q <= vc_d; mc_q <= mc_d; cf_q <= cf_d;
      root_q <= root_d; k_q <= k_d;
      vis_q <= vis_d; ons_q <= ons_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q <= m_d; beg_q <= beg_d; end_q <= end_d;
    cur_q <= cur_d; x_q <= x_d; s_q <= s_d; e_q <= e_d;
    curlow_q <= curlow_d;
    ob_q <= ob_d;
  end

  assign in_stall_o  = !(state_q == ST_LOAD);
  assign out_valid_o = ov_q;
  assign out_word_o  = ob_q;

  logic [LinkW-1:0] pend_e_q, pend_e_d;
  logic pend_last_q, pend_last_d;
  always_ff @(posedge clk_i) begin
    pend_e_q <= pend_e_d; pend_last_q <= pend_last_d;
  end

  assign is_last_node = (k_q == 7'd1) && (m_q + 7'd1 == end_q);

  always_comb begin
    state_d = state_q;
    ecnt_d = ecnt_q; ovf_d = ovf_q;
    sp_d = sp_q; dep_d = dep_q; vc_d = vc_q; mc_d = mc_q; cf_d = cf_q;
    root_d = root_q; k_d = k_q; m_d = m_q; beg_d = beg_q; end_d = end_q;
    cur_d = cur_q; x_d = x_q; s_d = s_q; e_d = e_q;
    curlow_d = curlow_q;
    vis_d = vis_q; ons_d = ons_q;
    ob_d = ob_q; ov_d = ov_q && out_stall_i;
    pend_e_d = pend_e_q; pend_last_d = pend_last_q;
    head_a = s_q; tail_a = s_q; edge_a = e_q[EdgeW-1:0]; nxt_a = e_q[EdgeW-1:0];
    disc_a = x_q; low_a = cur_q; nstk_a = sp_q[NodeW-1:0];
    fr_a = NodeW'(dep_q - 7'd1); ml_a = m_q[NodeW-1:0]; ce_a = cf_q[NodeW-1:0];
    head_we = 1'b0; tail_we = 1'b0; tgt_we = 1'b0; nxt_we = 1'b0;
    disc_we = 1'b0; low_we = 1'b0; nstk_we = 1'b0; fr_we = 1'b0; fe_we = 1'b0;
    ml_we = 1'b0; ce_we = 1'b0;
    head_wd = '0; nxt_wd = LinkW'(MaxEdges); fe_wd = '0; tail_wd = '0;
    tgt_wd = '0; nstk_wd = '0; fn_wd = '0; ml_wd = '0;
    disc_wd = vc_q; low_wd = vc_q; ce_wd = mc_q;

    case (state_q)
      ST_CLEAR: begin
        head_a = root_q[NodeW-1:0]; head_we = 1'b1; head_wd = LinkW'(MaxEdges);
        root_d = root_q + 7'd1;
        if (root_q == 7'(MaxNodes - 1)) begin
          root_d = '0; state_d = ST_LOAD;
          vis_d = '0; ons_d = '0; ecnt_d = '0; ovf_d = 1'b0;
          sp_d = '0; dep_d = '0; vc_d = 7'd1; mc_d = '0; cf_d = '0;
        end
      end
      ST_LOAD: begin
        head_a = in_word_i.source_node; tail_a = in_word_i.source_node;
        if (in_acc) begin
          s_d = in_word_i.source_node;
          pend_last_d = in_word_i.last_item;
          if (edge_ok && ecnt_q >= LinkW'(MaxEdges)) ovf_d = 1'b1;
          if (edge_ok && ecnt_q < LinkW'(MaxEdges)) begin
            edge_a = ecnt_q[EdgeW-1:0]; nxt_a = ecnt_q[EdgeW-1:0];
            tgt_we = 1'b1; tgt_wd = in_word_i.target_node;
            nxt_we = 1'b1; nxt_wd = LinkW'(MaxEdges);
            pend_e_d = ecnt_q;
            ecnt_d = ecnt_q + 11'd1;
            state_d = ST_LOAD_WR;
          end else if (in_word_i.last_item) begin
            state_d = ST_ROOT;
          end
        end
      end
      ST_LOAD_WR: begin
        // head/tail read of source available
        if (head_rd >= LinkW'(MaxEdges)) begin
          head_we = 1'b1; head_wd = pend_e_q;
        end else begin
          nxt_a = tail_rd; nxt_we = 1'b1; nxt_wd = pend_e_q;
        end
        tail_we = 1'b1; tail_wd = pend_e_q[EdgeW-1:0];
        state_d = pend_last_q ? ST_ROOT : ST_LOAD;
      end
      ST_ROOT: begin
        if (root_q >= n_eff) begin
          k_d = cf_q; state_d = (cf_q == '0) ? ST_CLEAR : ST_OUT_RD;
          root_d = '0;
          end_d = mc_q;
        end else if (vis_q[root_q[NodeW-1:0]]) begin
          root_d = root_q + 7'd1;
        end else begin
          x_d = root_q[NodeW-1:0]; s_d = root_q[NodeW-1:0];
          state_d = ST_ENTER;
        end
      end
      ST_ENTER: begin
        // x_q holds node being entered and s_q is loaded with it; head read issued
        head_a = x_q; s_d = x_q;
        disc_a = x_q; disc_we = 1'b1; disc_wd = vc_q;
        low_a = x_q; low_we = 1'b1; low_wd = vc_q;
        vc_d = vc_q + 7'd1;
        vis_d[x_q] = 1'b1; ons_d[x_q] = 1'b1;
        nstk_a = sp_q[NodeW-1:0]; nstk_we = 1'b1; nstk_wd = x_q;
        sp_d = sp_q + 7'd1;
        state_d = ST_FRAME_WT;
      end
      ST_FRAME_WT: begin
        fr_a = dep_q[NodeW-1:0]; fr_we = 1'b1; fn_wd = s_q; fe_wd = head_rd;
        dep_d = dep_q + 7'd1;
        state_d = ST_FRAME_RD;
      end
      ST_FRAME_RD: begin
        // read top frame
        state_d = ST_EDGE_WT;
      end
      ST_EDGE_WT: begin
        cur_d = fnode_rd; e_d = fedge_rd;
        low_a = fnode_rd; disc_a = fnode_rd;
        edge_a = fedge_rd[EdgeW-1:0]; nxt_a = fedge_rd[EdgeW-1:0];
        state_d = (fedge_rd < LinkW'(MaxEdges)) ? ST_TGT_WT : ST_FIN;
      end
      ST_TGT_WT: begin
        // tgt_rd, nxt_rd, low_rd(cur) valid
        fe_we = 1'b1; fe_wd = nxt_rd; fr_a = NodeW'(dep_q - 7'd1);
        x_d = tgt_rd; curlow_d = low_rd;
        if ({1'b0, tgt_rd} >= n_eff) begin
          state_d = ST_FRAME_RD;
        end else if (!vis_q[tgt_rd]) begin
          state_d = ST_ENTER;
        end else if (ons_q[tgt_rd]) begin
          disc_a = tgt_rd; state_d = ST_PAR_WT; s_d = cur_q;
          m_d = '0;
        end else begin
          state_d = ST_FRAME_RD;
        end
      end
      ST_PAR_WT: begin
        // disc_rd of x valid; compare against low of cur
        if (m_q == '0) begin
          if (disc_rd < curlow_q) begin
            low_a = cur_q; low_we = 1'b1; low_wd = disc_rd;
          end
          state_d = ST_FRAME_RD;
        end else begin
          // parent update: low_rd is parent's low
          if (low_rd > curlow_q) begin
            low_a = x_q; low_we = 1'b1; low_wd = curlow_q;
          end
          state_d = ST_FRAME_RD;
        end
      end
      ST_FIN: begin
        // low_rd/disc_rd of cur valid
        curlow_d = low_rd;
        if (low_rd == disc_rd) begin
          nstk_a = NodeW'(sp_q - 7'd1);
          state_d = ST_POP_WT;
        end else begin
          dep_d = dep_q - 7'd1;
          fr_a = NodeW'(dep_q - 7'd2);
          state_d = ST_PAR_RD;
        end
      end
      ST_POP_WT: begin
        sp_d = sp_q - 7'd1;
        ons_d[nstk_rd] = 1'b0;
        ml_a = mc_q[NodeW-1:0]; ml_we = 1'b1; ml_wd = nstk_rd;
        mc_d = mc_q + 7'd1;
        if (nstk_rd == cur_q || sp_q == 7'd1) begin
          ce_a = cf_q[NodeW-1:0]; ce_we = 1'b1; ce_wd = mc_q + 7'd1;
          cf_d = cf_q + 7'd1;
          dep_d = dep_q - 7'd1;
          fr_a = NodeW'(dep_q - 7'd2);
          state_d = ST_PAR_RD;
        end else begin
          nstk_a = NodeW'(sp_q - 7'd2);
          state_d = ST_POP_RD;
        end
      end
      ST_POP_RD: begin
        nstk_a = NodeW'(sp_q - 7'd1);
        state_d = ST_POP_WT;
      end
      ST_PAR_RD: begin
        // fnode_rd of parent valid if depth > 0
        if (dep_q == '0) begin
          root_d = root_q + 7'd1; state_d = ST_ROOT;
        end else if (ons_q[cur_q]) begin
          x_d = fnode_rd; low_a = fnode_rd; m_d = 7'd1;
          state_d = ST_PAR_WT;
        end else begin
          state_d = ST_FRAME_RD;
        end
      end
      ST_OUT_RD: begin
        // start of component k is the end of component k-1
        ce_a = NodeW'(k_q - 7'd2);
        state_d = ST_OUT_WT;
      end
      ST_OUT_WT: begin
        beg_d = (k_q >= 7'd2) ? cend_rd : '0;
        m_d = beg_d;
        ml_a = beg_d[NodeW-1:0];
        state_d = ST_OUT;
      end
      ST_OUT: begin
        ml_a = m_q[NodeW-1:0];
        if (!ov_d) begin
          ov_d = 1'b1;
          ob_d.total_components   = cf_q;
          ob_d.component_position = cf_q - k_q + 7'd1;
          ob_d.node_id            = mem_rd;
          ob_d.last_in_component  = (m_q + 7'd1 == end_q);
          ob_d.last_of_all        = is_last_node;
          ob_d.edges_dropped      = ovf_q;
          if (is_last_node) begin
            state_d = ST_CLEAR;
          end else if (m_q + 7'd1 == end_q) begin
            k_d = k_q - 7'd1;
            end_d = beg_q;
            state_d = ST_OUT_RD;
          end else begin
            m_d = m_q + 7'd1;
            ml_a = NodeW'(m_q + 7'd1);
          end
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  property p_out_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o);
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("output word changed under stall");

  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_LOAD) |-> in_stall_o)
    else $error("input accepted outside load");

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sp_q <= 7'(MaxNodes)) && (dep_q <= 7'(MaxNodes)))
    else $error("stack pointer beyond capacity");

  a_edges_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ecnt_q <= LinkW'(MaxEdges))
    else $error("edge count beyond capacity");

endmodule : tarjan_scc_finder
`default_nettype wire
